>>> hw/rtl/qmm_pkg.sv
`default_nettype none
package qmm_pkg;

    localparam int STICK_W  = 11;
    localparam int DEMAND_W = 12;
    localparam int MOTOR_W  = 12;
    localparam int MIX_W    = 14;
    localparam int CMD_W    = 10;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_MOTORS = 4;

    localparam logic signed [STICK_W-1:0] ARM_LOW_LIMIT  = -11'sd480;
    localparam logic signed [STICK_W-1:0] ARM_HIGH_LIMIT = 11'sd480;
    localparam logic signed [MIX_W-1:0]   CMD_SPAN       = 14'sd1000;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LAYOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MOTOR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MOTOR    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DISARMED     = 2'd3;

    localparam logic LAYOUT_PLUS = 1'b0;
    localparam logic LAYOUT_X    = 1'b1;

    localparam logic [MOTOR_W-1:0] MIN_MOTOR_RESET = 12'd1000;
    localparam logic [MOTOR_W-1:0] MAX_MOTOR_RESET = 12'd2000;
    localparam logic [MOTOR_W-1:0] DISARMED_RESET  = 12'd1000;

    typedef struct packed {
        logic               frame_layout;
        logic [MOTOR_W-1:0] min_motor_value;
        logic [MOTOR_W-1:0] max_motor_value;
        logic [MOTOR_W-1:0] disarmed_motor_value;
    } t_cfg;

    typedef struct packed {
        logic signed [DEMAND_W-1:0] throttle;
        logic signed [DEMAND_W-1:0] roll;
        logic signed [DEMAND_W-1:0] pitch;
        logic signed [DEMAND_W-1:0] yaw;
    } t_demand;

    typedef logic [NUM_MOTORS-1:0][MOTOR_W-1:0] t_motor_arr;

endpackage
`default_nettype wire

>>> hw/rtl/quad_motor_mixer_with_arming.sv
`default_nettype none
// Quad motor mixer with stick arming. One control tick is one input beat and
// gives one result beat. A beat is registered on input, checked for the arming
// gesture and mixed into four plus or X frame motor commands in one pass, and
// lands in the output register. A new beat is taken every cycle unless i_ready
// stalls the output, set by the single register-to-register mix and clamp path.
// Configuration writes are taken every cycle and are meant for idle periods.
module quad_motor_mixer_with_arming (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic signed [qmm_pkg::STICK_W-1:0]    i_throttle_stick,
    input  wire logic signed [qmm_pkg::STICK_W-1:0]    i_yaw_stick,
    input  wire logic signed [qmm_pkg::DEMAND_W-1:0]   i_throttle_demand,
    input  wire logic signed [qmm_pkg::DEMAND_W-1:0]   i_roll_demand,
    input  wire logic signed [qmm_pkg::DEMAND_W-1:0]   i_pitch_demand,
    input  wire logic signed [qmm_pkg::DEMAND_W-1:0]   i_yaw_demand,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic [qmm_pkg::MOTOR_W-1:0]                o_motor_out_0,
    output logic [qmm_pkg::MOTOR_W-1:0]                o_motor_out_1,
    output logic [qmm_pkg::MOTOR_W-1:0]                o_motor_out_2,
    output logic [qmm_pkg::MOTOR_W-1:0]                o_motor_out_3,
    output logic                                       o_is_armed,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [qmm_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [qmm_pkg::MOTOR_W-1:0]           i_cfg_data
);
    import qmm_pkg::*;

    t_cfg    r_cfg;
    logic    r_s1_valid;
    logic signed [STICK_W-1:0] r_thr_stick;
    logic signed [STICK_W-1:0] r_yaw_stick;
    t_demand r_demand;
    logic    r_out_valid;
    t_motor_arr r_motor;
    logic    r_is_armed;

    logic    s1_advance;
    logic    armed;
    t_motor_arr motor;

    assign s1_advance = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready    = !r_s1_valid || s1_advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_layout         <= LAYOUT_PLUS;
            r_cfg.min_motor_value      <= MIN_MOTOR_RESET;
            r_cfg.max_motor_value      <= MAX_MOTOR_RESET;
            r_cfg.disarmed_motor_value <= DISARMED_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FRAME_LAYOUT: r_cfg.frame_layout         <= i_cfg_data[0];
                REG_MIN_MOTOR:    r_cfg.min_motor_value      <= i_cfg_data;
                REG_MAX_MOTOR:    r_cfg.max_motor_value      <= i_cfg_data;
                REG_DISARMED:     r_cfg.disarmed_motor_value <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_thr_stick       <= i_throttle_stick;
            r_yaw_stick       <= i_yaw_stick;
            r_demand.throttle <= i_throttle_demand;
            r_demand.roll     <= i_roll_demand;
            r_demand.pitch    <= i_pitch_demand;
            r_demand.yaw      <= i_yaw_demand;
        end
    end

    qmm_arm u_arm (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (s1_advance),
        .i_throttle_stick (r_thr_stick),
        .i_yaw_stick      (r_yaw_stick),
        .o_armed          (armed)
    );

    qmm_mix u_mix (
        .i_demand (r_demand),
        .i_cfg    (r_cfg),
        .i_armed  (armed),
        .o_motor  (motor)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (s1_advance) begin
            r_motor    <= motor;
            r_is_armed <= armed;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_motor_out_0 = r_motor[0];
    assign o_motor_out_1 = r_motor[1];
    assign o_motor_out_2 = r_motor[2];
    assign o_motor_out_3 = r_motor[3];
    assign o_is_armed    = r_is_armed;

endmodule
`default_nettype wire

>>> hw/rtl/qmm_arm.sv
`default_nettype none
module qmm_arm (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_advance,
    input  wire logic signed [qmm_pkg::STICK_W-1:0] i_throttle_stick,
    input  wire logic signed [qmm_pkg::STICK_W-1:0] i_yaw_stick,
    output logic                              o_armed
);
    import qmm_pkg::*;

    logic r_armed;
    logic n_armed;

    always_comb begin
        n_armed = r_armed;
        if (i_throttle_stick < ARM_LOW_LIMIT) begin
            if (i_yaw_stick < ARM_LOW_LIMIT) begin
                n_armed = 1'b0;
            end else if (i_yaw_stick > ARM_HIGH_LIMIT) begin
                n_armed = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
        end else if (i_advance) begin
            r_armed <= n_armed;
        end
    end

    assign o_armed = n_armed;

endmodule
`default_nettype wire

>>> hw/rtl/qmm_mix.sv
`default_nettype none
module qmm_mix (
    input  wire qmm_pkg::t_demand    i_demand,
    input  wire qmm_pkg::t_cfg       i_cfg,
    input  wire logic                i_armed,
    output qmm_pkg::t_motor_arr      o_motor
);
    import qmm_pkg::*;

    logic signed [MIX_W-1:0] t, r, p, y;
    logic signed [MIX_W-1:0] mix [NUM_MOTORS];
    logic [CMD_W-1:0]        cmd [NUM_MOTORS];
    logic [MOTOR_W:0]        offs [NUM_MOTORS];

    assign t = MIX_W'(i_demand.throttle);
    assign r = MIX_W'(i_demand.roll);
    assign p = MIX_W'(i_demand.pitch);
    assign y = MIX_W'(i_demand.yaw);

    always_comb begin
        if (i_cfg.frame_layout == LAYOUT_X) begin
            mix[0] = t - r + p - y;
            mix[1] = t - r - p + y;
            mix[2] = t + r + p + y;
            mix[3] = t + r - p - y;
        end else begin
            mix[0] = t - r - y;
            mix[1] = t + r - y;
            mix[2] = t + p + y;
            mix[3] = t - p + y;
        end
    end

    // clamp to 0..1000, add min offset, clamp to max; disarmed value when not armed
    always_comb begin
        for (int k = 0; k < NUM_MOTORS; k++) begin
            if (mix[k] < 0) begin
                cmd[k] = '0;
            end else if (mix[k] > CMD_SPAN) begin
                cmd[k] = CMD_SPAN[CMD_W-1:0];
            end else begin
                cmd[k] = mix[k][CMD_W-1:0];
            end
            offs[k] = {1'b0, i_cfg.min_motor_value} + (MOTOR_W+1)'(cmd[k]);
            if (!i_armed) begin
                o_motor[k] = i_cfg.disarmed_motor_value;
            end else if (offs[k] > {1'b0, i_cfg.max_motor_value}) begin
                o_motor[k] = i_cfg.max_motor_value;
            end else begin
                o_motor[k] = offs[k][MOTOR_W-1:0];
            end
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/qmm_check.sv
`default_nettype none
module qmm_check (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  o_valid,
    input  wire logic                                  i_ready,
    input  wire logic [qmm_pkg::MOTOR_W-1:0]           o_motor_out_0,
    input  wire logic [qmm_pkg::MOTOR_W-1:0]           o_motor_out_1,
    input  wire logic [qmm_pkg::MOTOR_W-1:0]           o_motor_out_2,
    input  wire logic [qmm_pkg::MOTOR_W-1:0]           o_motor_out_3,
    input  wire logic                                  o_is_armed,
    input  wire logic                                  i_cfg_valid,
    input  wire logic                                  o_cfg_ready,
    input  wire logic [qmm_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [qmm_pkg::MOTOR_W-1:0]           i_cfg_data
);
    import qmm_pkg::*;

    logic [MOTOR_W-1:0] r_max;
    logic [MOTOR_W-1:0] r_dis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_MOTOR_RESET;
            r_dis <= DISARMED_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_MAX_MOTOR) begin
                r_max <= i_cfg_data;
            end
            if (i_cfg_index == REG_DISARMED) begin
                r_dis <= i_cfg_data;
            end
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result beat valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_motor_out_0)
            && $stable(o_motor_out_1) && $stable(o_motor_out_2)
            && $stable(o_motor_out_3) && $stable(o_is_armed))
        else $error("stalled result beat changed");

    a_disarmed_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_armed |-> o_motor_out_0 == r_dis && o_motor_out_1 == r_dis
            && o_motor_out_2 == r_dis && o_motor_out_3 == r_dis)
        else $error("disarmed motors not at disarmed value");

    a_armed_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_armed |-> o_motor_out_0 <= r_max && o_motor_out_1 <= r_max
            && o_motor_out_2 <= r_max && o_motor_out_3 <= r_max)
        else $error("armed motor above max");

endmodule

bind quad_motor_mixer_with_arming qmm_check u_qmm_check (.*);
`default_nettype wire
